// ----- rtl/core/ede_pkg.sv -----
// Shared constants, word types and controller/datapath interface types.
package ede_pkg;

  localparam int unsigned MAX_LEN  = 64;
  localparam int unsigned CNT_W    = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned DIST_W   = 7;
  localparam int unsigned DIST_MAX = (1 << DIST_W) - 1;

  localparam logic [1:0] KIND_SOURCE  = 2'd0;
  localparam logic [1:0] KIND_TARGET  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
  } ede_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } ede_out_t;

  typedef struct packed {
    logic append;
    logic start;
    logic init_step;
    logic row_rd;
    logic row_wr;
    logic cell_rd;
    logic cell_wr;
    logic finish;
  } ede_cmd_t;

  typedef struct packed {
    logic s_zero;
    logic t_zero;
    logic j_last;
    logic i_last;
    logic out_free;
  } ede_status_t;

  function automatic logic [DIST_W-1:0] sat_dist(logic [CNT_W-1:0] v);
    if (32'(v) > DIST_MAX) begin
      return DIST_W'(DIST_MAX);
    end
    return DIST_W'(v);
  endfunction

endpackage

// ----- rtl/core/edit_distance_engine_top.sv -----
// Levenshtein edit distance engine top level.
// Append words (source or target byte) are stored in order; bytes beyond MAX_LEN are dropped
// and flagged. A compute word for source length s and target length t sweeps the single cost
// row memory, which is read and then written once per cell. No word is taken while a compute
// runs; a finished result waits in the output register while further append words are taken.
// Compute clears both strings and the flag.
module edit_distance_engine_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ede_pkg::ede_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ede_pkg::ede_out_t out_word_o
);

  ede_pkg::ede_cmd_t    cmd;
  ede_pkg::ede_status_t status;

  ede_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (in_word_i.kind),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ede_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- rtl/core/ede_ctrl.sv -----
// Sequencer for loading, row sweeps and result hand-off.
module ede_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           kind_i,
  output logic                 in_ready_o,
  input  ede_pkg::ede_status_t status_i,
  output ede_pkg::ede_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_INIT    = 7'b0000010,
    ST_ROW_RD  = 7'b0000100,
    ST_ROW_WR  = 7'b0001000,
    ST_CELL_RD = 7'b0010000,
    ST_CELL_WR = 7'b0100000,
    ST_DONE    = 7'b1000000
  } ede_state_e;

  ede_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == ede_pkg::KIND_COMPUTE) begin
            cmd_o.start = 1'b1;
            state_d     = ST_INIT;
          end else begin
            cmd_o.append = 1'b1;
          end
        end
      end
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (status_i.j_last) begin
          state_d = status_i.s_zero ? ST_DONE : ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        cmd_o.row_rd = 1'b1;
        state_d      = ST_ROW_WR;
      end
      ST_ROW_WR: begin
        cmd_o.row_wr = 1'b1;
        if (!status_i.t_zero) begin
          state_d = ST_CELL_RD;
        end else begin
          state_d = status_i.i_last ? ST_DONE : ST_ROW_RD;
        end
      end
      ST_CELL_RD: begin
        cmd_o.cell_rd = 1'b1;
        state_d       = ST_CELL_WR;
      end
      ST_CELL_WR: begin
        cmd_o.cell_wr = 1'b1;
        if (!status_i.j_last) begin
          state_d = ST_CELL_RD;
        end else begin
          state_d = status_i.i_last ? ST_DONE : ST_ROW_RD;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/ede_datapath.sv -----
// Byte stores, cost row memory, cell update and result register.
module ede_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ede_pkg::ede_in_t     in_word_i,
  input  ede_pkg::ede_cmd_t    cmd_i,
  output ede_pkg::ede_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ede_pkg::ede_out_t    out_word_o
);

  localparam int unsigned CW = ede_pkg::CNT_W;
  localparam int unsigned IW = ede_pkg::IDX_W;

  logic [7:0]    src_mem [ede_pkg::MAX_LEN];
  logic [7:0]    tgt_mem [ede_pkg::MAX_LEN];
  logic [CW-1:0] row_mem [ede_pkg::MAX_LEN + 1];

  logic [CW-1:0] src_cnt_q, tgt_cnt_q;
  logic          dropped_q;
  logic [CW-1:0] i_q, j_q;
  logic [CW-1:0] diag_q, left_q;
  logic [7:0]    src_rd_q, tgt_rd_q;
  logic [CW-1:0] row_rd_q;
  logic          out_valid_q;
  ede_pkg::ede_out_t out_q;

  logic [CW-1:0] im1, jm1;
  logic [CW-1:0] min_a, min_b, cell_val, dist_sel;
  logic          row_end;
  logic          row_we;
  logic [CW-1:0] row_waddr, row_wdata, row_raddr;

  assign im1 = i_q - CW'(1);
  assign jm1 = j_q - CW'(1);

  assign min_a    = (left_q < row_rd_q) ? left_q : row_rd_q;
  assign min_b    = (min_a < diag_q) ? min_a : diag_q;
  assign cell_val = (src_rd_q == tgt_rd_q) ? diag_q : min_b + CW'(1);

  assign status_o.s_zero   = (src_cnt_q == '0);
  assign status_o.t_zero   = (tgt_cnt_q == '0);
  assign status_o.j_last   = (j_q == tgt_cnt_q);
  assign status_o.i_last   = (i_q == src_cnt_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign row_end  = (cmd_i.row_wr && status_o.t_zero) || (cmd_i.cell_wr && status_o.j_last);
  assign dist_sel = status_o.s_zero ? tgt_cnt_q : left_q;

  always_comb begin
    row_we    = 1'b0;
    row_waddr = j_q;
    row_wdata = cell_val;
    row_raddr = j_q;
    if (cmd_i.init_step) begin
      row_we    = 1'b1;
      row_wdata = j_q;
    end else if (cmd_i.row_wr) begin
      row_we    = 1'b1;
      row_waddr = '0;
      row_wdata = i_q;
    end else if (cmd_i.cell_wr) begin
      row_we = 1'b1;
    end
    if (cmd_i.row_rd) begin
      row_raddr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && in_word_i.kind == ede_pkg::KIND_SOURCE &&
        32'(src_cnt_q) < ede_pkg::MAX_LEN) begin
      src_mem[src_cnt_q[IW-1:0]] <= in_word_i.symbol;
    end
    if (cmd_i.append && in_word_i.kind == ede_pkg::KIND_TARGET &&
        32'(tgt_cnt_q) < ede_pkg::MAX_LEN) begin
      tgt_mem[tgt_cnt_q[IW-1:0]] <= in_word_i.symbol;
    end
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (cmd_i.row_rd) begin
      src_rd_q <= src_mem[im1[IW-1:0]];
    end
    if (cmd_i.cell_rd) begin
      tgt_rd_q <= tgt_mem[jm1[IW-1:0]];
    end
    if (cmd_i.row_rd || cmd_i.cell_rd) begin
      row_rd_q <= row_mem[row_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      i_q <= CW'(1);
      j_q <= '0;
    end else if (cmd_i.init_step || cmd_i.cell_wr) begin
      j_q <= j_q + CW'(1);
    end else if (cmd_i.row_wr) begin
      j_q <= CW'(1);
    end
    if (row_end) begin
      i_q <= i_q + CW'(1);
    end
    if (cmd_i.row_wr) begin
      diag_q <= row_rd_q;
      left_q <= i_q;
    end else if (cmd_i.cell_wr) begin
      diag_q <= row_rd_q;
      left_q <= cell_val;
    end
    if (cmd_i.finish) begin
      out_q.distance <= ede_pkg::sat_dist(dist_sel);
      out_q.overflow <= dropped_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cnt_q   <= '0;
      tgt_cnt_q   <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        src_cnt_q   <= '0;
        tgt_cnt_q   <= '0;
        dropped_q   <= 1'b0;
        out_valid_q <= 1'b1;
      end else begin
        if (out_ready_i) begin
          out_valid_q <= 1'b0;
        end
        if (cmd_i.append && in_word_i.kind == ede_pkg::KIND_SOURCE) begin
          if (32'(src_cnt_q) < ede_pkg::MAX_LEN) begin
            src_cnt_q <= src_cnt_q + CW'(1);
          end else begin
            dropped_q <= 1'b1;
          end
        end
        if (cmd_i.append && in_word_i.kind == ede_pkg::KIND_TARGET) begin
          if (32'(tgt_cnt_q) < ede_pkg::MAX_LEN) begin
            tgt_cnt_q <= tgt_cnt_q + CW'(1);
          end else begin
            dropped_q <= 1'b1;
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- rtl/core/ede_checker.sv -----
// Port-level checks for the edit distance engine, bound to the top level.
module ede_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ede_pkg::ede_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ede_pkg::ede_out_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_word_o.distance) <= ede_pkg::MAX_LEN)
    else $error("distance beyond string capacity");

  a_busy_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.kind == ede_pkg::KIND_COMPUTE |=> !in_ready_o)
    else $error("input taken in the cycle after a compute word");

  a_result_from_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a compute in progress");

endmodule

bind edit_distance_engine_top ede_checker u_ede_checker (.*);

// ----- dv/edit_distance_checker.sv -----
// Checker: watches both channels, predicts each edit distance and compares the results.
module edit_distance_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  ede_pkg::ede_in_t  in_word_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  ede_pkg::ede_out_t out_word_i,
  output int                mismatches_o,
  output int                outstanding_o,
  output int                answered_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]        src_bytes [ede_pkg::MAX_LEN];
  logic [7:0]        tgt_bytes [ede_pkg::MAX_LEN];
  int                src_len = 0;
  int                tgt_len = 0;
  bit                dropped = 1'b0;
  ede_pkg::ede_out_t expected_distances [$];

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    answered_o    = 0;
  end

  function automatic ede_pkg::ede_out_t levenshtein();
    int                row [ede_pkg::MAX_LEN + 1];
    int                diag;
    int                above;
    int                cost;
    ede_pkg::ede_out_t res;
    for (int j = 0; j <= tgt_len; j++) begin
      row[j] = j;
    end
    for (int i = 1; i <= src_len; i++) begin
      diag   = row[0];
      row[0] = i;
      for (int j = 1; j <= tgt_len; j++) begin
        above = row[j];
        if (src_bytes[i-1] == tgt_bytes[j-1]) begin
          cost = diag;
        end else begin
          cost = row[j-1];
          if (above < cost) cost = above;
          if (diag < cost) cost = diag;
          cost = cost + 1;
        end
        diag   = above;
        row[j] = cost;
      end
    end
    res.distance = (row[tgt_len] > int'(ede_pkg::DIST_MAX)) ?
                   ede_pkg::DIST_W'(ede_pkg::DIST_MAX) : ede_pkg::DIST_W'(row[tgt_len]);
    res.overflow = dropped;
    return res;
  endfunction

  task automatic note_failure(input string what);
    if (mismatches_o < 10) begin
      $display("%0t: %s", $realtime, what);
    end
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ede_pkg::ede_out_t want;
    if (!rst_ni) begin
      src_len = 0;
      tgt_len = 0;
      dropped = 1'b0;
      expected_distances.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        answered_o++;
        if (expected_distances.size() == 0) begin
          note_failure($sformatf("unexpected result: distance %0d overflow %0b",
                                 out_word_i.distance, out_word_i.overflow));
        end else begin
          want = expected_distances.pop_front();
          if (out_word_i.distance !== want.distance || out_word_i.overflow !== want.overflow) begin
            note_failure($sformatf("mismatch: distance exp %0d got %0d, overflow exp %0b got %0b",
                                   want.distance, out_word_i.distance,
                                   want.overflow, out_word_i.overflow));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (in_word_i.kind)
          ede_pkg::KIND_SOURCE: begin
            if (src_len < int'(ede_pkg::MAX_LEN)) begin
              src_bytes[src_len] = in_word_i.symbol;
              src_len++;
            end else begin
              dropped = 1'b1;
            end
          end
          ede_pkg::KIND_TARGET: begin
            if (tgt_len < int'(ede_pkg::MAX_LEN)) begin
              tgt_bytes[tgt_len] = in_word_i.symbol;
              tgt_len++;
            end else begin
              dropped = 1'b1;
            end
          end
          ede_pkg::KIND_COMPUTE: begin
            expected_distances = {expected_distances, levenshtein()};
            src_len = 0;
            tgt_len = 0;
            dropped = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
    outstanding_o = expected_distances.size();
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top: drives append and compute words into the engine and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  KIND_UNUSED     = 2'd3;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  localparam int unsigned WORD_BUDGET     = 1250;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  ede_pkg::ede_in_t  in_word_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  ede_pkg::ede_out_t out_word_o;
  int                mismatches;
  int                outstanding;
  int                answered;

  edit_distance_engine_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  edit_distance_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_word_i     (in_word_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_word_i    (out_word_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .answered_o    (answered)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic ede_pkg::ede_in_t make_word(logic [1:0] kind, logic [7:0] symbol);
    ede_pkg::ede_in_t w;
    w.kind   = kind;
    w.symbol = symbol;
    return w;
  endfunction

  // Hold valid high until taken; return at the following falling edge.
  task automatic offer(input ede_pkg::ede_in_t w);
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    int  stretch;
    int  mode;
    bit  held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(32, 300);
      repeat (stretch) begin
        @(negedge clk_i);
        if (!held && answered >= 15) begin
          held = 1'b1;
          out_ready_i <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        end
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  initial begin
    ede_pkg::ede_in_t directed [$];
    ede_pkg::ede_in_t words [$];
    ede_pkg::ede_in_t src_part [$];
    ede_pkg::ede_in_t tgt_part [$];
    int unsigned      counted;
    int unsigned      seq;
    int unsigned      s_len;
    int unsigned      t_len;
    int unsigned      base;
    int unsigned      burst;
    int unsigned      gap;
    int unsigned      idx;
    int unsigned      pause_at;
    bit               narrow;

    directed = {directed, make_word(ede_pkg::KIND_COMPUTE, 8'hFF)};
    directed = {directed, make_word(ede_pkg::KIND_SOURCE, 8'h00)};
    directed = {directed, make_word(ede_pkg::KIND_COMPUTE, 8'h00)};
    directed = {directed, make_word(ede_pkg::KIND_TARGET, 8'hFF)};
    directed = {directed, make_word(ede_pkg::KIND_TARGET, 8'h00)};
    directed = {directed, make_word(ede_pkg::KIND_COMPUTE, 8'h5A)};
    directed = {directed, make_word(ede_pkg::KIND_SOURCE, 8'hFF)};
    directed = {directed, make_word(ede_pkg::KIND_TARGET, 8'hFF)};
    directed = {directed, make_word(ede_pkg::KIND_COMPUTE, 8'h00)};
    directed = {directed, make_word(ede_pkg::KIND_SOURCE, 8'h00)};
    directed = {directed, make_word(ede_pkg::KIND_TARGET, 8'hFF)};
    directed = {directed, make_word(ede_pkg::KIND_COMPUTE, 8'hA5)};
    directed = {directed, make_word(KIND_UNUSED, 8'hAA)};
    directed = {directed, make_word(ede_pkg::KIND_SOURCE, 8'h55)};
    directed = {directed, make_word(KIND_UNUSED, 8'h55)};
    directed = {directed, make_word(ede_pkg::KIND_TARGET, 8'h55)};
    directed = {directed, make_word(ede_pkg::KIND_COMPUTE, 8'h00)};
    directed = {directed, make_word(ede_pkg::KIND_SOURCE, 8'h61)};
    directed = {directed, make_word(ede_pkg::KIND_SOURCE, 8'h62)};
    directed = {directed, make_word(ede_pkg::KIND_SOURCE, 8'h63)};
    directed = {directed, make_word(ede_pkg::KIND_TARGET, 8'h61)};
    directed = {directed, make_word(ede_pkg::KIND_TARGET, 8'h63)};
    directed = {directed, make_word(ede_pkg::KIND_COMPUTE, 8'h00)};

    counted = 23;
    seq     = 0;
    while (counted < WORD_BUDGET) begin
      if (seq == 0) begin
        s_len = 66;
        t_len = 0;
      end else if (seq == 1) begin
        s_len = 0;
        t_len = 65;
      end else if (seq == 2) begin
        s_len = 64;
        t_len = 64;
      end else if ($urandom_range(0, 29) == 0) begin
        s_len = $urandom_range(56, 70);
        t_len = $urandom_range(56, 70);
      end else begin
        s_len = $urandom_range(0, 12);
        t_len = $urandom_range(0, 12);
      end
      narrow = ($urandom_range(0, 2) != 0);
      base   = $urandom_range(0, 255);
      src_part.delete();
      tgt_part.delete();
      repeat (s_len) begin
        src_part = {src_part, make_word(ede_pkg::KIND_SOURCE,
                    narrow ? 8'(base + $urandom_range(0, 3)) : 8'($urandom))};
      end
      repeat (t_len) begin
        tgt_part = {tgt_part, make_word(ede_pkg::KIND_TARGET,
                    narrow ? 8'(base + $urandom_range(0, 3)) : 8'($urandom))};
      end
      while (src_part.size() + tgt_part.size() > 0) begin
        if ($urandom_range(0, 11) == 0) begin
          words = {words, make_word(KIND_UNUSED, 8'($urandom))};
        end
        if (tgt_part.size() == 0 || (src_part.size() != 0 && $urandom_range(0, 1) == 0)) begin
          words = {words, src_part.pop_front()};
        end else begin
          words = {words, tgt_part.pop_front()};
        end
      end
      words = {words, make_word(ede_pkg::KIND_COMPUTE, 8'($urandom))};
      counted += s_len + t_len + 1;
      seq++;
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[k]) begin
      offer(directed[k]);
    end
    drain();

    pause_at = words.size() / 2;
    idx      = 0;
    while (idx < words.size()) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && idx < words.size()) begin
        offer(words[idx]);
        idx++;
        burst--;
        if (idx == pause_at) begin
          drain();
        end
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
